// ----- design/vn_pkg.sv -----
package vn_pkg;

  // Field formats of one transaction.
  localparam int IN_W = 16;
  localparam int FRAC_W = 14;
  localparam int OUT_W = FRAC_W + 2;

  // Internal widths of the square and root-search datapath.
  localparam int SQ_W = 2 * IN_W;
  localparam int SUM_W = 2 * IN_W + 2;
  localparam int LIM_W = 2 * IN_W + 2 * FRAC_W + 2;
  localparam int P_W = 2 * FRAC_W + 2 * IN_W + 6;
  localparam int Q_W = FRAC_W + 2 * IN_W + 6;
  localparam int N_W = FRAC_W + 1;

  // Pipeline depth: three front stages, one per result bit, one output stage.
  localparam int FRONT_DEPTH = 3;
  localparam int LATENCY = FRONT_DEPTH + N_W + 1;

  typedef struct packed {
    logic signed [IN_W-1:0] comp_x;
    logic signed [IN_W-1:0] comp_y;
    logic signed [IN_W-1:0] comp_z;
  } vec_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] unit_x;
    logic signed [OUT_W-1:0] unit_y;
    logic signed [OUT_W-1:0] unit_z;
    logic                    was_zero;
  } vec_out_t;

  // What the front end hands to each component lane.
  typedef struct packed {
    logic [SUM_W-1:0] sumsq;
    logic [LIM_W-1:0] limit;
    logic             neg;
  } lane_in_t;

  // Magnitude of a two's complement component.
  function automatic logic [IN_W-1:0] magnitude(input logic signed [IN_W-1:0] v);
    logic [IN_W-1:0] r;
    r = v[IN_W-1] ? IN_W'(-v) : IN_W'(v);
    return r;
  endfunction

endpackage

// ----- design/vector3_normalize_top.sv -----
// Three-component vector normalization.
// A transaction enters on operand when start is high and busy is low; busy
// is always low, so a new vector may enter in every cycle. Components are
// signed 16-bit integers. The result carries each component divided by the
// Euclidean length, in signed Q1.14 (16384 is 1.0), rounded to nearest with
// ties away from zero. A zero vector gives zero components and was_zero set.
// Each result is on result for exactly one cycle, marked by done, and is
// taken at the end of that cycle; the receiver cannot stall.
// There are 19 register stages: three front stages (magnitude, square,
// sum), fifteen root-search stages, one for each result bit, and one
// output register. Throughput is one vector per cycle.
// Reset clears all valid bits, so no done pulse follows reset until a new
// transaction has gone through the pipeline.
module vector3_normalize_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  vn_pkg::vec_in_t  operand,
  output logic             done,
  output vn_pkg::vec_out_t result
);

  localparam int SEARCH = vn_pkg::N_W;

  logic              front_vld;
  logic              front_zero;
  vn_pkg::lane_in_t  lx;
  vn_pkg::lane_in_t  ly;
  vn_pkg::lane_in_t  lz;
  logic signed [vn_pkg::OUT_W-1:0] ux;
  logic signed [vn_pkg::OUT_W-1:0] uy;
  logic signed [vn_pkg::OUT_W-1:0] uz;
  logic [SEARCH-1:0] vld_line;
  logic [SEARCH-1:0] zero_line;

  assign busy = 1'b0;

  vn_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (start),
    .vec       (operand),
    .valid_out (front_vld),
    .zero      (front_zero),
    .lane_x    (lx),
    .lane_y    (ly),
    .lane_z    (lz)
  );

  vn_lane u_lane_x (.clk(clk), .lane(lx), .unit(ux));
  vn_lane u_lane_y (.clk(clk), .lane(ly), .unit(uy));
  vn_lane u_lane_z (.clk(clk), .lane(lz), .unit(uz));

  // Zero flag travels beside the root search.
  always_ff @(posedge clk) begin
    zero_line <= {zero_line[SEARCH-2:0], front_zero};
  end

  // Valid bits of the search stages and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_line <= '0;
      done <= 1'b0;
    end else begin
      vld_line <= {vld_line[SEARCH-2:0], front_vld};
      done <= vld_line[SEARCH-1];
    end
  end

  // Output register; a zero vector forces zero components.
  always_ff @(posedge clk) begin
    result.unit_x   <= zero_line[SEARCH-1] ? '0 : ux;
    result.unit_y   <= zero_line[SEARCH-1] ? '0 : uy;
    result.unit_z   <= zero_line[SEARCH-1] ? '0 : uz;
    result.was_zero <= zero_line[SEARCH-1];
  end

endmodule

// ----- design/vn_prep.sv -----
module vn_prep (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid_in,
  input  vn_pkg::vec_in_t     vec,
  output logic                valid_out,
  output logic                zero,
  output vn_pkg::lane_in_t    lane_x,
  output vn_pkg::lane_in_t    lane_y,
  output vn_pkg::lane_in_t    lane_z
);

  logic [vn_pkg::IN_W-1:0] mag [0:2];
  logic [2:0]              neg_a;
  logic                    vld_a;
  logic [vn_pkg::SQ_W-1:0] sq [0:2];
  logic [2:0]              neg_b;
  logic                    vld_b;
  logic [vn_pkg::SUM_W-1:0] sum;

  // Stage A: magnitudes and signs.
  always_ff @(posedge clk) begin
    mag[0] <= vn_pkg::magnitude(vec.comp_x);
    mag[1] <= vn_pkg::magnitude(vec.comp_y);
    mag[2] <= vn_pkg::magnitude(vec.comp_z);
    neg_a <= {vec.comp_z[vn_pkg::IN_W-1], vec.comp_y[vn_pkg::IN_W-1],
              vec.comp_x[vn_pkg::IN_W-1]};
  end

  // Stage B: one square per component.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq[i] <= vn_pkg::SQ_W'(mag[i] * mag[i]);
    end
    neg_b <= neg_a;
  end

  // Stage C: sum of squares and the scaled square of each magnitude.
  assign sum = vn_pkg::SUM_W'(sq[0]) + vn_pkg::SUM_W'(sq[1]) + vn_pkg::SUM_W'(sq[2]);

  always_ff @(posedge clk) begin
    lane_x.sumsq <= sum;
    lane_y.sumsq <= sum;
    lane_z.sumsq <= sum;
    lane_x.limit <= vn_pkg::LIM_W'(sq[0]) << (2 * vn_pkg::FRAC_W + 2);
    lane_y.limit <= vn_pkg::LIM_W'(sq[1]) << (2 * vn_pkg::FRAC_W + 2);
    lane_z.limit <= vn_pkg::LIM_W'(sq[2]) << (2 * vn_pkg::FRAC_W + 2);
    lane_x.neg <= neg_b[0];
    lane_y.neg <= neg_b[1];
    lane_z.neg <= neg_b[2];
    zero <= (sum == '0);
  end

  // Valid bits of the three front stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      valid_out <= 1'b0;
    end else begin
      vld_a <= valid_in;
      vld_b <= vld_a;
      valid_out <= vld_b;
    end
  end

endmodule

// ----- design/vn_lane.sv -----
module vn_lane (
  input  logic                          clk,
  input  vn_pkg::lane_in_t              lane,
  output logic signed [vn_pkg::OUT_W-1:0] unit
);

  localparam int F = vn_pkg::FRAC_W;

  // Per stage: running (2n-1)^2*S, (2n-1)*S, result bits so far.
  logic [vn_pkg::P_W-1:0]   p   [0:F+1];
  logic [vn_pkg::Q_W-1:0]   q   [0:F+1];
  logic [vn_pkg::N_W-1:0]   n   [0:F+1];
  logic [vn_pkg::SUM_W-1:0] s   [0:F+1];
  logic [vn_pkg::LIM_W-1:0] lim [0:F+1];
  logic                     neg [0:F+1];

  // Start from n = 0, which stands for t = 2n-1 = -1.
  assign p[0]   = vn_pkg::P_W'(lane.sumsq);
  assign q[0]   = vn_pkg::Q_W'(-vn_pkg::Q_W'(lane.sumsq));
  assign n[0]   = '0;
  assign s[0]   = lane.sumsq;
  assign lim[0] = lane.limit;
  assign neg[0] = lane.neg;

  // One stage per result bit, most significant first. Setting bit K moves t
  // up by 2^(K+1), so the square grows by 2^(K+2)*t*S + 2^(2K+2)*S.
  for (genvar g = 0; g <= F; g++) begin : g_step
    localparam int K = F - g;
    logic [vn_pkg::P_W-1:0] cand;
    logic                   fits;

    assign cand = p[g]
                + ({{(vn_pkg::P_W - vn_pkg::Q_W){q[g][vn_pkg::Q_W-1]}}, q[g]} << (K + 2))
                + (vn_pkg::P_W'(s[g]) << (2 * K + 2));
    assign fits = (cand <= vn_pkg::P_W'(lim[g]));

    always_ff @(posedge clk) begin
      if (fits) begin
        p[g+1] <= cand;
        q[g+1] <= q[g] + (vn_pkg::Q_W'(s[g]) << (K + 1));
        n[g+1] <= n[g] | (vn_pkg::N_W'(1) << K);
      end else begin
        p[g+1] <= p[g];
        q[g+1] <= q[g];
        n[g+1] <= n[g];
      end
      s[g+1]   <= s[g];
      lim[g+1] <= lim[g];
      neg[g+1] <= neg[g];
    end
  end

  // Apply the sign to the rounded magnitude.
  assign unit = neg[F+1] ? -vn_pkg::OUT_W'(n[F+1]) : vn_pkg::OUT_W'(n[F+1]);

endmodule

// ----- tb/sv/vector3_normalize_checker.sv -----
module vector3_normalize_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  vn_pkg::vec_in_t  operand,
  input  logic             done,
  input  vn_pkg::vec_out_t result,
  output int               fail_count,
  output int               pending
);

  vn_pkg::vec_out_t unit_queue[$];

  // Rounded magnitude of mag * 2^FRAC_W / sqrt(sumsq), ties away from zero,
  // found as the largest n with (2n-1)^2 * sumsq <= mag^2 * 2^(2*FRAC_W+2).
  function automatic logic [vn_pkg::FRAC_W:0] round_scaled(logic [vn_pkg::IN_W:0] mag,
                                                           logic [63:0] sumsq);
    logic [127:0] lhs;
    logic [127:0] rhs;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] mid;
    logic [63:0] odd;
    lo = 0;
    hi = 32'd1 << vn_pkg::FRAC_W;
    rhs = (128'(mag) * 128'(mag)) << (2 * vn_pkg::FRAC_W + 2);
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      odd = 64'(2 * mid - 1);
      lhs = 128'(odd * odd) * 128'(sumsq);
      if (lhs <= rhs) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return lo[vn_pkg::FRAC_W:0];
  endfunction

  // Expected unit vector for one input vector.
  function automatic vn_pkg::vec_out_t normalize_vector(vn_pkg::vec_in_t v);
    logic signed [vn_pkg::IN_W-1:0] c[3];
    logic [vn_pkg::IN_W:0] mag[3];
    logic [63:0] sumsq;
    logic [vn_pkg::OUT_W-1:0] q[3];
    vn_pkg::vec_out_t r;
    c[0] = v.comp_x;
    c[1] = v.comp_y;
    c[2] = v.comp_z;
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = c[i] < 0 ? (vn_pkg::IN_W+1)'(-int'(c[i])) : (vn_pkg::IN_W+1)'(c[i]);
      sumsq += 64'(mag[i]) * 64'(mag[i]);
    end
    r = '0;
    if (sumsq == 0) begin
      r.was_zero = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      q[i] = vn_pkg::OUT_W'(round_scaled(mag[i], sumsq));
      if (c[i] < 0) q[i] = -q[i];
    end
    r.unit_x = q[0];
    r.unit_y = q[1];
    r.unit_z = q[2];
    return r;
  endfunction

  // Predict on each accepted transaction and compare each result.
  always @(posedge clk) begin
    vn_pkg::vec_out_t want;
    int errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (start && !busy) unit_queue.push_back(normalize_vector(operand));
      if (done) begin
        if (unit_queue.size() == 0) begin
          $error("Result with no transaction outstanding: %h", result);
          errs++;
        end else begin
          want = unit_queue.pop_front();
          if (result.unit_x !== want.unit_x) begin
            $error("unit_x expected %0d actual %0d", want.unit_x, result.unit_x);
            errs++;
          end
          if (result.unit_y !== want.unit_y) begin
            $error("unit_y expected %0d actual %0d", want.unit_y, result.unit_y);
            errs++;
          end
          if (result.unit_z !== want.unit_z) begin
            $error("unit_z expected %0d actual %0d", want.unit_z, result.unit_z);
            errs++;
          end
          if (result.was_zero !== want.was_zero) begin
            $error("was_zero expected %0d actual %0d", want.was_zero, result.was_zero);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    pending <= unit_queue.size();
  end
endmodule

// ----- tb/sv/vector3_normalize_top_test.sv -----
module vector3_normalize_top_test;

  localparam int RANDOM_COUNT = 2000;
  localparam int IDLE_LIMIT = 2000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  vn_pkg::vec_in_t operand;
  logic done;
  vn_pkg::vec_out_t result;
  int fail_count;
  int pending;
  int idle_cycles;

  vector3_normalize_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operand(operand), .done(done), .result(result)
  );

  vector3_normalize_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operand(operand),
    .done(done), .result(result), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Presents one vector, after a random gap when gaps is set, and holds it until accepted.
  task automatic send_vector(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z, input bit gaps);
    int wait_cycles;
    wait_cycles = gaps ? $urandom_range(0, 3) : 0;
    if (wait_cycles > 0) begin
      start <= 1'b0;
      repeat (wait_cycles) @(negedge clk);
    end
    start <= 1'b1;
    operand <= {x, y, z};
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Random component: zero, full range, small values, or the extremes.
  function automatic logic [15:0] pick_comp();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'($signed($urandom_range(0, 20)) - 10);
      2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    bit gaps;
    rst = 1'b1;
    start = 1'b0;
    operand = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zero vector, single axes, extremes and mixed signs.
    send_vector(16'h0000, 16'h0000, 16'h0000, 0);
    send_vector(16'h0001, 16'h0000, 16'h0000, 0);
    send_vector(16'h0000, 16'hffff, 16'h0000, 0);
    send_vector(16'h0000, 16'h0000, 16'h8000, 0);
    send_vector(16'h7fff, 16'h0000, 16'h0000, 0);
    send_vector(16'h8000, 16'h8000, 16'h8000, 0);
    send_vector(16'h7fff, 16'h7fff, 16'h7fff, 0);
    send_vector(16'h8000, 16'h7fff, 16'h0001, 0);
    send_vector(16'h0001, 16'h0001, 16'h0001, 0);
    send_vector(16'h0003, 16'hfffc, 16'h0000, 0);
    send_vector(16'h0002, 16'h0001, 16'hfffe, 0);
    send_vector(16'h0001, 16'h0001, 16'h0000, 0);
    send_vector(16'h5555, 16'haaaa, 16'h0001, 0);
    send_vector(16'hffff, 16'hffff, 16'hffff, 0);
    send_vector(16'h7fff, 16'h0001, 16'h8000, 0);

    // Random vectors, in stretches that each run either with or without gaps.
    for (int i = 0; i < RANDOM_COUNT; i++) begin
      if (i % 100 == 0) gaps = $urandom_range(0, 2) != 0;
      send_vector(pick_comp(), pick_comp(), pick_comp(), gaps);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (vn_pkg::LATENCY + 5) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ----- files.f -----
design/vn_pkg.sv
design/vn_prep.sv
design/vn_lane.sv
design/vector3_normalize_top.sv
tb/sv/vector3_normalize_checker.sv
tb/sv/vector3_normalize_top_test.sv
